// ----- sv/pee_pkg.sv -----
// Package for the prefix expression evaluator: sizes, status codes, operator
// and state types, and symbol decoding helpers. No dependencies.
package pee_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_POW
	} alu_op_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_DIV,
		A_POW_MUL,
		A_POW_SQR,
		A_DONE
	} alu_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_B,
		S_OPER,
		S_ALU,
		S_REPORT,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

	function automatic logic sym_is_digit(input logic [7:0] sym);
		return (sym >= CH_ZERO) && (sym <= CH_NINE);
	endfunction

	function automatic logic sym_is_op(input logic [7:0] sym);
		return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_MUL) ||
			(sym == CH_DIV) || (sym == CH_POW);
	endfunction

	function automatic alu_op_t sym_to_op(input logic [7:0] sym);
		alu_op_t op;
		unique case (sym)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_MUL:   op = OP_MUL;
			CH_DIV:   op = OP_DIV;
			default:  op = OP_POW;
		endcase
		return op;
	endfunction

endpackage

// ----- sv/pee_stack.sv -----
// Value stack storage: one write port and one registered read port.
// Depends on pee_pkg for the depth and data width.
module pee_stack
	import pee_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/pee_alu.sv -----
// Shared arithmetic unit: add, subtract, one multiplier reused for power by
// squaring, and a bit-serial restoring divider. Depends on pee_pkg.
module pee_alu
	import pee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	alu_state_t           state_q, state_d;
	logic [DATA_W-1:0]    acc_q, sq_q, k_q, rem_q, result_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;

	logic [DATA_W-1:0]    mul_a, mul_b;
	logic [2*DATA_W-1:0]  prod_full;
	logic [DATA_W-1:0]    prod;
	logic [DATA_W:0]      rem_sh, diff;
	logic [DATA_W-1:0]    rem_next, q_next;
	logic [DATA_W-1:0]    abs_a, abs_b;
	logic [DATA_W-1:0]    pow_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						OP_DIV:  state_d = A_DIV;
						OP_POW:  state_d = req.b[DATA_W-1] ? A_DONE : A_POW_MUL;
						default: state_d = A_DONE;
					endcase
				end
			end
			A_DIV: begin
				if (cnt_q == '1) begin
					state_d = A_DONE;
				end
			end
			A_POW_MUL: state_d = (k_q == '0) ? A_DONE : A_POW_SQR;
			A_POW_SQR: state_d = A_POW_MUL;
			A_DONE:    state_d = A_IDLE;
			default:   state_d = A_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			A_POW_MUL: begin
				mul_a = acc_q;
				mul_b = sq_q;
			end
			A_POW_SQR: begin
				mul_a = sq_q;
				mul_b = sq_q;
			end
			default: begin
				mul_a = req.a;
				mul_b = req.b;
			end
		endcase
		rsp.done   = (state_q == A_DONE);
		rsp.result = result_q;
	end

	assign prod_full = mul_a * mul_b;
	assign prod      = prod_full[DATA_W-1:0];
	assign rem_sh    = {rem_q, k_q[DATA_W-1]};
	assign diff      = rem_sh - {1'b0, sq_q};
	assign rem_next  = diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
	assign q_next    = {k_q[DATA_W-2:0], ~diff[DATA_W]};
	assign abs_a     = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
	assign abs_b     = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;

	always_comb begin
		if (req.a == DATA_W'(1)) begin
			pow_neg = DATA_W'(1);
		end else if (req.a == '1) begin
			pow_neg = req.b[0] ? '1 : DATA_W'(1);
		end else begin
			pow_neg = '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						OP_ADD: result_q <= req.a + req.b;
						OP_SUB: result_q <= req.a - req.b;
						OP_MUL: result_q <= prod;
						OP_DIV: begin
							k_q   <= abs_a;
							sq_q  <= abs_b;
							rem_q <= '0;
							cnt_q <= '0;
							neg_q <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
						end
						default: begin
							result_q <= pow_neg;
							acc_q    <= DATA_W'(1);
							sq_q     <= req.a;
							k_q      <= req.b;
						end
					endcase
				end
			end
			A_DIV: begin
				rem_q <= rem_next;
				k_q   <= q_next;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					result_q <= neg_q ? (~q_next + 1'b1) : q_next;
				end
			end
			A_POW_MUL: begin
				if (k_q == '0) begin
					result_q <= acc_q;
				end else if (k_q[0]) begin
					acc_q <= prod;
				end
			end
			A_POW_SQR: begin
				sq_q <= prod;
				k_q  <= k_q >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/prefix_expression_evaluator_core.sv -----
// Top level of the prefix expression evaluator: symbol sequencer, value stack
// and shared arithmetic unit. Depends on pee_pkg, pee_stack and pee_alu.
//
// Symbols of a prefix expression enter on the s_ group, last character first,
// one request at a time; s_tlast marks the first character of the expression.
// A digit is pushed in S_DECODE, where an unknown symbol or a stacking error is
// also flagged. An operator reads its operands in S_RD_B and S_OPER, where a
// division by zero is flagged, and otherwise runs in the arithmetic unit: divide
// bit-serially, and power by the square-and-multiply loop through the single
// multiplier. The request marked by s_tlast then passes S_REPORT for the stack
// read of the top and S_EMIT before its result is loaded on the m_ group.
// Each result carries the top of the stack and a status; after an error the
// rest of the expression is ignored and the value reads zero.
// The output register holds a result until m_tready takes it; meanwhile the
// next symbols are accepted, and only a further result waits for the slot.
// Reset clears the stack count, the error and the output valid; the stack
// contents need no clearing.
module prefix_expression_evaluator_core
	import pee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] symbol
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [31:0] value, [34:32] status, [39:35] zero
);

	seq_state_t        state_q, state_d;
	logic [7:0]        sym_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q;
	status_t           err_q;
	logic [DATA_W-1:0] a_q;
	logic              m_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           out_status_q;

	logic              is_digit, is_op;
	logic              stack_full, too_few, div_zero, out_free;
	seq_state_t        fin_state;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;
	logic [CNT_W-1:0]  cnt_m1, cnt_m2;

	logic              err_set;
	status_t           err_val;
	logic              cnt_inc, cnt_dec, emit, cap_a;
	status_t           rep_status;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	pee_stack u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign is_digit   = sym_is_digit(sym_q);
	assign is_op      = sym_is_op(sym_q);
	assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
	assign too_few    = (cnt_q < CNT_W'(2));
	assign div_zero   = (sym_to_op(sym_q) == OP_DIV) && (mem_rdata == '0);
	assign out_free   = !m_valid_q || m_tready;
	assign fin_state  = last_q ? S_REPORT : S_IDLE;
	assign cnt_m1     = cnt_q - 1'b1;
	assign cnt_m2     = cnt_q - 2'd2;

	always_comb begin
		if (err_q != ST_OK) begin
			rep_status = err_q;
		end else if (cnt_q == '0) begin
			rep_status = ST_UNDERFLOW;
		end else begin
			rep_status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (err_q != ST_OK || is_digit || !is_op || too_few) begin
					state_d = fin_state;
				end else begin
					state_d = S_RD_B;
				end
			end
			S_RD_B:   state_d = S_OPER;
			S_OPER:   state_d = div_zero ? fin_state : S_ALU;
			S_ALU: begin
				if (alu_rsp.done) begin
					state_d = fin_state;
				end
			end
			S_REPORT: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == S_IDLE);
		mem_we        = 1'b0;
		mem_waddr     = cnt_q[ADDR_W-1:0];
		mem_wdata     = DATA_W'(sym_q - CH_ZERO);
		mem_raddr     = cnt_m1[ADDR_W-1:0];
		err_set       = 1'b0;
		err_val       = ST_OK;
		cnt_inc       = 1'b0;
		cnt_dec       = 1'b0;
		emit          = 1'b0;
		cap_a         = 1'b0;
		alu_req.start = 1'b0;
		alu_req.op    = sym_to_op(sym_q);
		alu_req.a     = a_q;
		alu_req.b     = mem_rdata;
		unique case (state_q)
			S_DECODE: begin
				if (err_q == ST_OK) begin
					priority if (is_digit) begin
						if (stack_full) begin
							err_set = 1'b1;
							err_val = ST_OVERFLOW;
						end else begin
							mem_we  = 1'b1;
							cnt_inc = 1'b1;
						end
					end else if (!is_op) begin
						err_set = 1'b1;
						err_val = ST_UNKNOWN;
					end else if (too_few) begin
						err_set = 1'b1;
						err_val = ST_UNDERFLOW;
					end else begin
					end
				end
			end
			S_RD_B: begin
				mem_raddr = cnt_m2[ADDR_W-1:0];
				cap_a     = 1'b1;
			end
			S_OPER: begin
				if (div_zero) begin
					err_set = 1'b1;
					err_val = ST_DIVZERO;
				end else begin
					alu_req.start = 1'b1;
				end
			end
			S_ALU: begin
				mem_waddr = cnt_m2[ADDR_W-1:0];
				mem_wdata = alu_rsp.result;
				if (alu_rsp.done) begin
					mem_we  = 1'b1;
					cnt_dec = 1'b1;
				end
			end
			S_EMIT: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			err_q     <= ST_OK;
			m_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				cnt_q <= '0;
				err_q <= ST_OK;
			end else begin
				if (cnt_inc) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (cnt_dec) begin
					cnt_q <= cnt_m1;
				end
				if (err_set) begin
					err_q <= err_val;
				end
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sym_q  <= s_tdata;
			last_q <= s_tlast;
		end
		if (cap_a) begin
			a_q <= mem_rdata;
		end
		if (emit) begin
			out_status_q <= rep_status;
			out_value_q  <= (rep_status == ST_OK) ? mem_rdata : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, out_status_q, out_value_q};

endmodule

// ----- dv/prefix_expression_evaluator_core_test.sv -----
// Self-checking testbench for prefix_expression_evaluator_core: random and directed
// prefix expressions checked against a built-in stack predictor.
// Depends on pee_pkg and the core RTL only.
module prefix_expression_evaluator_core_test
	import pee_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 800_000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned ITEM_TARGET = 650;
	localparam int unsigned DRAIN_GUARD = 100;

	typedef enum logic [1:0] {REQ_SYMBOL, REQ_DRAIN, REQ_HOLD} req_kind_t;

	typedef struct {
		req_kind_t  kind;
		logic [7:0] sym;
		logic       fin;
	} sym_req_t;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} eval_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // [7:0] symbol
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // [31:0] value, [34:32] status, [39:35] zero

	logic        hold_req = 1'b0;

	sym_req_t     sym_queue[$];
	logic [7:0]   expr_buf[$];
	eval_result_t pending_results[$];
	int unsigned  sym_total;
	int unsigned  errors;
	int unsigned  cycles;
	int unsigned  gap_left, drv_calm, stall_left, rcv_calm;

	logic [31:0]  stack_model [STACK_DEPTH];
	int unsigned  stack_fill;
	status_t      first_error;

	prefix_expression_evaluator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if (roll < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic [31:0] int_pow(input logic [31:0] base, input logic [31:0] expo);
		logic [31:0] acc, sq, k;
		if (expo[31]) begin
			if (base == 32'd1) return 32'd1;
			if (base == '1) return expo[0] ? '1 : 32'd1;
			return '0;
		end
		acc = 32'd1;
		sq = base;
		k = expo;
		while (k != 0) begin
			if (k[0]) acc = acc * sq;
			sq = sq * sq;
			k = k >> 1;
		end
		return acc;
	endfunction

	function automatic void eval_symbol(input logic [7:0] sym, input logic fin);
		logic [31:0]  a, b, r;
		eval_result_t res;
		if (first_error == ST_OK) begin
			if (sym >= CH_ZERO && sym <= CH_NINE) begin
				if (stack_fill >= STACK_DEPTH) begin
					first_error = ST_OVERFLOW;
				end else begin
					stack_model[stack_fill] = {24'd0, sym - CH_ZERO};
					stack_fill++;
				end
			end else if (!(sym == CH_PLUS || sym == CH_MINUS || sym == CH_MUL ||
					sym == CH_DIV || sym == CH_POW)) begin
				first_error = ST_UNKNOWN;
			end else if (stack_fill < 2) begin
				first_error = ST_UNDERFLOW;
			end else begin
				a = stack_model[stack_fill - 1];
				b = stack_model[stack_fill - 2];
				r = '0;
				case (sym)
					CH_PLUS:  r = a + b;
					CH_MINUS: r = a - b;
					CH_MUL:   r = a * b;
					CH_DIV: begin
						if (b == 0) first_error = ST_DIVZERO;
						else r = 32'(longint'($signed(a)) / longint'($signed(b)));
					end
					default:  r = int_pow(a, b);
				endcase
				if (first_error == ST_OK) begin
					stack_fill--;
					stack_model[stack_fill - 1] = r;
				end
			end
		end
		if (fin) begin
			res.status = first_error;
			if (res.status == ST_OK && stack_fill == 0) res.status = ST_UNDERFLOW;
			res.value = (res.status == ST_OK) ? stack_model[stack_fill - 1] : '0;
			pending_results.push_back(res);
			stack_fill = 0;
			first_error = ST_OK;
		end
	endfunction

	function automatic void commit_expr();
		foreach (expr_buf[i])
			sym_queue.push_back('{REQ_SYMBOL, expr_buf[i], logic'(i == expr_buf.size() - 1)});
		sym_total += expr_buf.size();
		expr_buf.delete();
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
		commit_expr();
	endfunction

	function automatic void append_well_formed(input int unsigned n_dig, input logic deep);
		int unsigned depth, left;
		string       ops;
		ops = "+-*/^";
		depth = 0;
		left = n_dig;
		while (left != 0 || depth > 1) begin
			if (left != 0 && (depth < 2 ||
					(depth < STACK_DEPTH && (deep || $urandom_range(0, 1) == 1)))) begin
				expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				depth++;
				left--;
			end else begin
				expr_buf.push_back(ops[$urandom_range(0, 4)]);
				depth--;
			end
		end
	endfunction

	// Request driver: issues queued symbols, honoring drain and hold markers.
	always @(posedge clk or negedge arst_n) begin
		logic       nxt_valid, nxt_last, nxt_hold;
		logic [7:0] nxt_data;
		sym_req_t   head;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			hold_req <= 1'b0;
			gap_left = 0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data = s_tdata;
			nxt_last = s_tlast;
			nxt_hold = 1'b0;
			if (s_tvalid && s_tready) begin
				eval_symbol(s_tdata, s_tlast);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (sym_queue.size() != 0) begin
					head = sym_queue[0];
					case (head.kind)
						REQ_DRAIN: begin
							if (pending_results.size() == 0) void'(sym_queue.pop_front());
						end
						REQ_HOLD: begin
							void'(sym_queue.pop_front());
							nxt_hold = 1'b1;
						end
						default: begin
							void'(sym_queue.pop_front());
							nxt_valid = 1'b1;
							nxt_data = head.sym;
							nxt_last = head.fin;
							gap_left = pick_gap(drv_calm);
						end
					endcase
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
			s_tlast <= nxt_last;
			hold_req <= nxt_hold;
		end
	end

	// Result-side backpressure, including the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (hold_req) begin
			m_tready <= 1'b0;
			stall_left = LONG_HOLD;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = pick_gap(rcv_calm);
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		eval_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %0d status %0d",
					$signed(m_tdata[31:0]), m_tdata[34:32]);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.value) begin
					$error("value: expected %0d, got %0d",
						$signed(want.value), $signed(m_tdata[31:0]));
					errors++;
				end
				if (m_tdata[34:32] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[34:32]);
					errors++;
				end
				if (m_tdata[39:35] !== 5'd0) begin
					$error("pad: expected 0, got %0d", m_tdata[39:35]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		string       corner_exprs [0:6];
		int unsigned roll, pos;
		logic        hold_done, drain_done;
		corner_exprs[0] = "10-156*+2^/";
		corner_exprs[1] = "10-10-^";
		corner_exprs[2] = "20-10-^";
		corner_exprs[3] = "10-1^";
		corner_exprs[4] = "10-0^";
		corner_exprs[5] = "10-5^";
		corner_exprs[6] = "99^9^8*";
		hold_done = 1'b0;
		drain_done = 1'b0;
		sym_total = 0;
		errors = 0;
		cycles = 0;
		stack_fill = 0;
		first_error = ST_OK;
		drv_calm = 0;
		rcv_calm = 0;

		add_text("5");
		add_text("+");
		add_text("07/");
		add_text("00^");
		add_text("27-");
		add_text("198*+");
		add_text("1x2+");
		add_text("12");
		expr_buf.push_back(8'hFF);
		commit_expr();
		expr_buf.push_back(8'h00);
		expr_buf.push_back("3");
		commit_expr();
		sym_queue.push_back('{REQ_DRAIN, 8'h00, 1'b0});

		while (sym_total < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				if ($urandom_range(0, 99) < 6) append_well_formed($urandom_range(20, 32), 1'b1);
				else append_well_formed($urandom_range(1, 8), 1'b0);
			end else if (roll < 74) begin
				add_text(corner_exprs[$urandom_range(0, 6)]);
				continue;
			end else if (roll < 78) begin
				repeat (STACK_DEPTH + 1) expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				repeat ($urandom_range(0, 3)) expr_buf.push_back(CH_PLUS);
			end else if (roll < 84) begin
				append_well_formed($urandom_range(1, 6), 1'b0);
				pos = $urandom_range(0, expr_buf.size());
				expr_buf.insert(pos, 8'($urandom_range(0, 255)));
			end else if (roll < 89) begin
				expr_buf.push_back(CH_MUL);
				append_well_formed($urandom_range(1, 4), 1'b0);
			end else if (roll < 94) begin
				repeat ($urandom_range(2, 5)) expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 1) == 1) expr_buf.push_back(CH_MINUS);
			end else begin
				repeat ($urandom_range(1, 4)) expr_buf.push_back(8'($urandom_range(0, 255)));
			end
			commit_expr();
			if (!hold_done && sym_total > 250) begin
				sym_queue.push_back('{REQ_HOLD, 8'h00, 1'b0});
				hold_done = 1'b1;
			end
			if (!drain_done && sym_total > 450) begin
				sym_queue.push_back('{REQ_DRAIN, 8'h00, 1'b0});
				drain_done = 1'b1;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (sym_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GUARD) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- prefix_expression_evaluator_core.f -----
sv/pee_pkg.sv
sv/pee_stack.sv
sv/pee_alu.sv
sv/prefix_expression_evaluator_core.sv
dv/prefix_expression_evaluator_core_test.sv
